// ===== hw/rtl/lvn_pkg.sv =====
// ----------------------------------------------------------------------------
// lvn_pkg
// Types and constants shared by the lattice value noise pipeline.
// ----------------------------------------------------------------------------
package lvn_pkg;

  localparam logic [31:0] HASH_INIT = 32'h9e3779b9;
  localparam logic [31:0] PRIME_X   = 32'h85ebca6b;
  localparam logic [31:0] PRIME_Y   = 32'hc2b2ae35;
  localparam logic [31:0] PRIME_Z   = 32'h27d4eb2f;
  localparam logic [31:0] MIX_A     = 32'h7feb352d;
  localparam logic [31:0] MIX_B     = 32'h846ca68b;

  localparam logic [1:0] MODE_1D = 2'd0;
  localparam logic [1:0] MODE_2D = 2'd1;

  // APB register addresses (word index)
  localparam logic [1:0] REG_SEED = 2'd0;

  typedef logic signed [17:0] corner_t;

endpackage

// ===== hw/rtl/lvn_hash.sv =====
// ----------------------------------------------------------------------------
// lvn_hash
// Corner hash: products of the cell with the axis primes are given, this
// stage runs the avalanche finaliser over registered steps and maps to
// [-1,1). One multiplier between registers; enable advances all stages.
// ----------------------------------------------------------------------------
module lvn_hash (
  input  logic                  clk,
  input  logic                  en,
  input  logic [31:0]           h_in,
  output lvn_pkg::corner_t      value
);

  logic [31:0] m1_r, m2_r, m3_r, m4_r;
  logic [31:0] a1, a2, a3;

  assign a1 = h_in ^ (h_in >> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= a1 * lvn_pkg::MIX_A;
      m2_r <= m1_r ^ (m1_r >> 15);
      m3_r <= m2_r * lvn_pkg::MIX_B;
      m4_r <= m3_r ^ (m3_r >> 16);
    end
  end

  assign a2 = m4_r >> 15;
  assign a3 = a2 - 32'd65536;
  assign value = lvn_pkg::corner_t'(a3[17:0]);

endmodule

// ===== hw/rtl/lvn_fade.sv =====
// ----------------------------------------------------------------------------
// lvn_fade
// Quintic fade weight of a 16-bit fraction, with the multiplies spread over the stages.
// Registered as t1_r/sq_r, cube_r/lin_r, cube_d_r/inner_r, then fp_r; enable advances all.
// ----------------------------------------------------------------------------
module lvn_fade (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] t,
  output logic [16:0] w
);

  logic [15:0] t1_r;
  logic [15:0] sq_r;
  logic [19:0] lin_r;
  logic [15:0] cube_r;
  logic [15:0] cube_d_r;
  logic [19:0] inner_r;
  logic [31:0] sqp;
  logic [35:0] lp;
  logic [31:0] cp;
  logic [36:0] fp_r;

  assign sqp = t * t;
  assign cp  = sq_r * t1_r;
  assign lp  = 36'(t1_r) * 36'(20'd983040 - 20'(t1_r) * 20'd6);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r     <= t;
      sq_r     <= sqp[31:16];
      cube_r   <= cp[31:16];
      lin_r    <= lp[35:16];
      // hold the cube one stage so it meets the inner term of the same request
      cube_d_r <= cube_r;
      inner_r  <= 20'd655360 - lin_r;
      fp_r     <= 37'(cube_d_r) * 37'(inner_r);
    end
  end

  assign w = fp_r[32:16];

endmodule

// ===== hw/rtl/lvn_lerp.sv =====
// ----------------------------------------------------------------------------
// lvn_lerp
// One registered blend step: a + floor(w*(b-a)/65536).
// ----------------------------------------------------------------------------
module lvn_lerp (
  input  logic             clk,
  input  logic             en,
  input  lvn_pkg::corner_t a,
  input  lvn_pkg::corner_t b,
  input  logic [16:0]      w,
  output lvn_pkg::corner_t y
);

  logic signed [18:0] d;
  logic signed [36:0] p;
  logic signed [18:0] s;

  assign d = 19'(b) - 19'(a);
  assign p = $signed({1'b0, w}) * d;
  assign s = 19'(a) + p[34:16];

  always_ff @(posedge clk) begin
    if (en) begin
      y <= s[17:0];
    end
  end

endmodule

// ===== hw/rtl/lattice_value_noise_top.sv =====
// ----------------------------------------------------------------------------
// lattice_value_noise_top
// Seeded lattice value noise in 1D, 2D or 3D with quintic fade.
// ----------------------------------------------------------------------------
// Takes one request every cycle unless the output is stalled and returns one sample
// per request, in order. The depth is set by the axis products, the corner combine,
// the hash chain (two registered multiplies with xorshifts) and then the
// three blend stages; the fade weights run alongside the hash. A stall on the
// output side freezes the whole pipeline; while a finished sample waits, no
// new request is accepted.
module lattice_value_noise_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // noise_value[17:0], zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DEPTH = 9;

  logic [31:0]      seed_r;
  logic [DEPTH-1:0] vld_r;
  logic             en;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == lvn_pkg::REG_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == lvn_pkg::REG_SEED) begin
      seed_r <= cfg_pwdata;
    end
  end

  // advance when the final stage is empty or being drained
  assign en         = !vld_r[DEPTH-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // stage 0: split coordinates
  logic [1:0]  mode;
  logic [31:0] cx, cy, cz;
  logic [15:0] fx, fy, fz;
  logic [31:0] raw [3];
  logic [31:0] lat_idx [3];
  logic [15:0] fr [3];

  assign mode   = in_tuser;
  assign raw[0] = in_tdata[31:0];
  assign raw[1] = in_tdata[63:32];
  assign raw[2] = in_tdata[95:64];

  for (genvar k = 0; k < 3; k++) begin : g_split
    logic [47:0] sh;
    logic [31:0] fm;
    assign lat_idx[k] = 32'($signed(raw[k]) >>> FRAC_BITS);
    assign fm         = raw[k] & ((32'd1 << FRAC_BITS) - 32'd1);
    assign sh         = (48'(fm) << 16) >> FRAC_BITS;
    assign fr[k]      = sh[15:0];
  end

  assign cx = lat_idx[0];
  assign cy = (mode == lvn_pkg::MODE_1D) ? 32'd0 : lat_idx[1];
  assign cz = (mode == lvn_pkg::MODE_1D || mode == lvn_pkg::MODE_2D) ? 32'd0 : lat_idx[2];
  assign fx = fr[0];
  assign fy = (mode == lvn_pkg::MODE_1D) ? 16'd0 : fr[1];
  assign fz = (mode == lvn_pkg::MODE_1D || mode == lvn_pkg::MODE_2D) ? 16'd0 : fr[2];

  // stage 1: axis products for both corner offsets
  logic [31:0] px_r [2];
  logic [31:0] py_r [2];
  logic [31:0] pz_r [2];
  logic [31:0] s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        px_r[j] <= (cx + 32'(j)) * lvn_pkg::PRIME_X;
        py_r[j] <= (cy + 32'(j)) * lvn_pkg::PRIME_Y;
        pz_r[j] <= (cz + 32'(j)) * lvn_pkg::PRIME_Z;
      end
      s1_r <= seed_r + lvn_pkg::HASH_INIT;
    end
  end

  // stage 2: combine into eight corner hashes
  logic [31:0]      hc_r [8];
  lvn_pkg::corner_t cv [8];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        hc_r[i] <= s1_r ^ px_r[i & 1] ^ py_r[(i >> 1) & 1] ^ pz_r[(i >> 2) & 1];
      end
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_hash
    lvn_hash u_hash (.clk(clk), .en(en), .h_in(hc_r[i]), .value(cv[i]));
  end

  // fade weights: delay fractions to align with corner values (6 stages)
  logic [15:0] fd_r [3][2];
  logic [16:0] wx, wy, wz;
  logic [16:0] wy_d_r, wz_d_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      fd_r[0][0] <= fx;
      fd_r[1][0] <= fy;
      fd_r[2][0] <= fz;
      for (int k = 0; k < 3; k++) begin
        fd_r[k][1] <= fd_r[k][0];
      end
      wy_d_r    <= wy;
      wz_d_r[0] <= wz;
      wz_d_r[1] <= wz_d_r[0];
    end
  end

  lvn_fade u_fx (.clk(clk), .en(en), .t(fd_r[0][1]), .w(wx));
  lvn_fade u_fy (.clk(clk), .en(en), .t(fd_r[1][1]), .w(wy));
  lvn_fade u_fz (.clk(clk), .en(en), .t(fd_r[2][1]), .w(wz));

  // blends: x (stage 7), y (stage 8), z (stage 9)
  lvn_pkg::corner_t bx [4];
  lvn_pkg::corner_t by [2];
  lvn_pkg::corner_t bz;

  for (genvar i = 0; i < 4; i++) begin : g_bx
    lvn_lerp u_lx (.clk(clk), .en(en), .a(cv[2*i]), .b(cv[2*i+1]), .w(wx), .y(bx[i]));
  end
  for (genvar i = 0; i < 2; i++) begin : g_by
    lvn_lerp u_ly (.clk(clk), .en(en), .a(bx[2*i]), .b(bx[2*i+1]), .w(wy_d_r), .y(by[i]));
  end
  lvn_lerp u_lz (.clk(clk), .en(en), .a(by[0]), .b(by[1]), .w(wz_d_r[1]), .y(bz));

  // clamp to [-1, 1]
  logic signed [17:0] res;
  always_comb begin
    res = bz;
    if (bz < -18'sd65536) begin
      res = -18'sd65536;
    end else if (bz > 18'sd65536) begin
      res = 18'sd65536;
    end
  end

  assign out_tdata = {6'd0, res};

  // a held output never changes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output changed while stalled");

  // sample is within [-1, 1]
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[17:0]) >= -18'sd65536 &&
                    $signed(out_tdata[17:0]) <= 18'sd65536))
    else $error("sample out of range");

  // a stalled pipeline keeps its valid bits
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Lattice value noise testbench
// Streams mode and coordinate requests into the noise pipeline under random
// gaps on both sides and checks every sample against an in-bench predictor.
// The predictor follows the lattice hash, the quintic fade and the truncating
// blends, and it is rerun for several seed settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
  } noise_req_t;

  localparam int FRAC = 16;
  localparam int LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lattice_value_noise_top #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [31:0]       seed_model = '0;
  noise_req_t        pending_reqs[$];
  logic signed [17:0] expected_samples[$];
  int                errors = 0;
  int                samples_seen = 0;
  int                cycles = 0;
  int                in_gap = 0;
  int                out_gap = 0;
  bit                hold_send = 1'b0;

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz);
    logic [31:0] h;
    h = seed_model + lvn_pkg::HASH_INIT;
    h ^= cx * lvn_pkg::PRIME_X;
    h ^= cy * lvn_pkg::PRIME_Y;
    h ^= cz * lvn_pkg::PRIME_Z;
    h ^= h >> 16;
    h = h * lvn_pkg::MIX_A;
    h ^= h >> 15;
    h = h * lvn_pkg::MIX_B;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic longint corner_level(logic [31:0] cx, logic [31:0] cy,
                                          logic [31:0] cz);
    logic [31:0] h;
    h = lattice_hash(cx, cy, cz);
    return longint'({15'd0, h[31:15]}) - 65536;
  endfunction

  function automatic longint quintic_weight(longint t);
    longint t2, t3, inner;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    inner = 655360 - ((t * (983040 - 6 * t)) >>> 16);
    return (t3 * inner) >>> 16;
  endfunction

  // Arithmetic shift on longint floors toward minus infinity.
  function automatic longint lerp_floor(longint a, longint b, longint w);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic logic signed [17:0] noise_sample(noise_req_t r);
    logic [31:0] lat_idx[3];
    longint      w[3];
    longint      c[8];
    longint      x0, x1, x2, x3, y0, y1, res;
    logic [31:0] raw[3];
    longint      frac;
    raw[0] = r.cx;
    raw[1] = r.cy;
    raw[2] = r.cz;
    for (int d = 0; d < 3; d++) begin
      lat_idx[d] = '0;
      w[d] = 0;
      if (d == 0 || (d == 1 && r.mode != lvn_pkg::MODE_1D) ||
          (d == 2 && r.mode != lvn_pkg::MODE_1D && r.mode != lvn_pkg::MODE_2D)) begin
        lat_idx[d] = 32'($signed(raw[d]) >>> FRAC);
        frac = longint'(raw[d] & ((32'd1 << FRAC) - 1));
        w[d] = quintic_weight((frac << 16) >> FRAC);
      end
    end
    for (int i = 0; i < 8; i++)
      c[i] = corner_level(lat_idx[0] + 32'(i & 1), lat_idx[1] + 32'((i >> 1) & 1),
                          lat_idx[2] + 32'((i >> 2) & 1));
    x0 = lerp_floor(c[0], c[1], w[0]);
    x1 = lerp_floor(c[2], c[3], w[0]);
    x2 = lerp_floor(c[4], c[5], w[0]);
    x3 = lerp_floor(c[6], c[7], w[0]);
    y0 = lerp_floor(x0, x1, w[1]);
    y1 = lerp_floor(x2, x3, w[1]);
    res = lerp_floor(y0, y1, w[2]);
    if (res < -65536) res = -65536;
    if (res > 65536) res = 65536;
    return 18'(res);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Driver: present the head request; hold it until accepted.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_samples.push_back(noise_sample(pending_reqs.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // hold the request
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_send &&
                   !(in_tvalid && in_tready && pending_reqs.size() == 0)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_reqs[0].cz, pending_reqs[0].cy, pending_reqs[0].cx};
        in_tuser <= pending_reqs[0].mode;
        in_gap <= gap_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each sample against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        samples_seen <= samples_seen + 1;
        if (expected_samples.size() == 0) begin
          $error("unexpected sample noise_value=%0d", $signed(out_tdata[17:0]));
          errors <= errors + 1;
        end else begin
          if (out_tdata[17:0] !== expected_samples[0]) begin
            $error("noise_value expected %0d actual %0d", expected_samples[0],
                   $signed(out_tdata[17:0]));
            errors <= errors + 1;
          end else if (out_tdata[23:18] !== 6'd0) begin
            $error("fill expected 0 actual %0h", out_tdata[23:18]);
            errors <= errors + 1;
          end
          void'(expected_samples.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap <= gap_len();
      end
    end
    if (cycles >= LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_seed(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= lvn_pkg::REG_SEED;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    seed_model = value;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_tvalid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {{16{1'b0}}, 16'($urandom())} - 32'h0000_8000;
      2: return $urandom() | 32'h8000_0000;
      3: return {16'($urandom_range(0, 3)) - 16'd2, 16'($urandom())};
      4: return $urandom_range(0, 1) ? 32'h7fff_0000 | $urandom_range(0, 65535)
                                     : 32'h8000_0000 | $urandom_range(0, 65535);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic queue_random(int n);
    noise_req_t r;
    for (int i = 0; i < n; i++) begin
      r.mode = 2'($urandom());
      r.cx = rand_coord();
      r.cy = rand_coord();
      r.cz = rand_coord();
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    logic [31:0] seeds[4];
    logic [31:0] edges[6];
    noise_req_t  r;
    seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h1234_5678, 32'h8000_0001};
    edges = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h0001_8000, 32'hfffe_7fff};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_seed(32'h0);
    // directed: extremes of each coordinate in every mode
    for (int m = 0; m < 4; m++)
      for (int e = 0; e < 6; e++) begin
        r.mode = 2'(m);
        r.cx = edges[e];
        r.cy = edges[5 - e];
        r.cz = edges[(e + 2) % 6];
        pending_reqs.push_back(r);
      end
    wait_idle();
    foreach (seeds[s]) begin
      write_seed(seeds[s]);
      queue_random(130);
      // pause sending until every sample is back, then resume
      while (pending_reqs.size() > 65) @(posedge clk);
      hold_send = 1'b1;
      while (in_tvalid || expected_samples.size() > 0) @(posedge clk);
      hold_send = 1'b0;
      wait_idle();
      write_seed($urandom());
      queue_random(140);
      wait_idle();
    end
    $display("covered %0d samples over eight seed settings, all four modes,",
             samples_seen);
    $display("coordinate extremes and cell wrap, with random stalls on both sides");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lvn_pkg.sv
hw/rtl/lvn_hash.sv
hw/rtl/lvn_fade.sv
hw/rtl/lvn_lerp.sv
hw/rtl/lattice_value_noise_top.sv
verif/testbench.sv
